[src/chgs_pkg.sv]
// Package: widths, point type, state enums, product struct and a sign helper for the hull block.
package chgs_pkg;
  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int SIZE_BITS  = 6;
  localparam int DIF_BITS   = COORD_BITS + 1;
  localparam int PRD_BITS   = 2 * DIF_BITS;
  localparam int QLEN       = 4;
  localparam int QBITS      = $clog2(QLEN);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIF_BITS-1:0]   dif_t;
  typedef logic signed [PRD_BITS-1:0]   prd_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pt_t;

  typedef enum logic [1:0] {
    TURN_LEFT  = 2'd0,
    TURN_RIGHT = 2'd1,
    TURN_NONE  = 2'd2
  } turn_t;

  // Back end sequence: load, dedup, start point, sort, scan, emit
  typedef enum logic [3:0] {
    B_LOAD, B_DUP, B_MIN_RD, B_MIN, B_SORT_RD, B_CMP_LD, B_T1_EX, B_T1_CHK,
    B_T2_EX, B_T2_CHK, B_SCAN_INIT, B_SCAN_RD, B_SCAN_EX, B_SCAN_CHK, B_OUT
  } bst_t;

  // Registered cross products and differences; the back end classifies them.
  typedef struct packed {
    prd_t t1;
    prd_t t2;
    dif_t dx1;
    dif_t dy1;
    dif_t dx2;
    dif_t dy2;
  } tp_t;

  function automatic logic opp(dif_t a, dif_t b);
    opp = (a < 0 && b > 0) || (a > 0 && b < 0);
  endfunction
endpackage

[src/chgs_if.sv]
// Valid/ready stream interfaces for points and hull vertices.
interface chgs_in_if;
  import chgs_pkg::*;
  logic   valid;
  logic   ready;
  coord_t px;
  coord_t py;
  logic   final_point;
  modport source(output valid, px, py, final_point, input ready);
  modport sink(input valid, px, py, final_point, output ready);
endinterface

interface chgs_out_if;
  import chgs_pkg::*;
  logic                 valid;
  logic                 ready;
  coord_t               hx;
  coord_t               hy;
  logic [SIZE_BITS-1:0] vtx_count;
  logic                 dropped;
  logic                 end_of_hull;
  modport source(output valid, hx, hy, vtx_count, dropped, end_of_hull, input ready);
  modport sink(input valid, hx, hy, vtx_count, dropped, end_of_hull, output ready);
endinterface

[src/chgs_front.sv]
// Front end: accepts point items and queues them for the back end.
module chgs_front import chgs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  chgs_in_if.sink    in_ch,
  output logic       q_valid,
  output pt_t        q_data,
  input  logic       q_pop
);
  pt_t              mem_r [QLEN];
  logic [QBITS-1:0] wp_r, rp_r;
  logic [QBITS:0]   cnt_r;

  assign in_ch.ready = (cnt_r != (QBITS+1)'(QLEN));
  assign q_valid     = (cnt_r != '0);
  assign q_data      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mem_r[wp_r] <= '{x: in_ch.px, y: in_ch.py, last: in_ch.final_point};
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QBITS+1)'(in_ch.valid && in_ch.ready) - (QBITS+1)'(q_pop);
    end
  end
endmodule

[src/chgs_back.sv]
// Back end: point store, dedup, start point search, insertion sort, stack scan, output.
module chgs_back import chgs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  pt_t       q_data,
  output logic      q_pop,
  chgs_out_if.source out_ch
);
  // point store as x/y memories, read by index
  coord_t sx_r [MAX_POINTS];
  coord_t sy_r [MAX_POINTS];
  idx_t   ord_r [MAX_POINTS];
  idx_t   stk_r [MAX_POINTS];

  bst_t  st_r, st_nxt;
  cnt_t  cnt_r, i_r, k_r, sp_r;
  logic  ovf_r, dup_r;
  pt_t   cur_r;
  idx_t  best_r, curi_r, prvi_r;
  coord_t ox_r, oy_r;
  // three read points A,B,C
  coord_t ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  tp_t   tp_r;
  logic  ovld_r;
  coord_t ohx_r, ohy_r;
  logic  oend_r, odrop_r;
  logic [SIZE_BITS-1:0] osz_r;

  // turn classification of registered products
  turn_t  tr;
  prd_t   d1, d2;
  always_comb begin
    d1 = prd_t'(tp_r.dx1) * prd_t'(tp_r.dx1) + prd_t'(tp_r.dy1) * prd_t'(tp_r.dy1);
    d2 = prd_t'(tp_r.dx2) * prd_t'(tp_r.dx2) + prd_t'(tp_r.dy2) * prd_t'(tp_r.dy2);
    if (tp_r.t1 == tp_r.t2) begin
      if (opp(tp_r.dx1, tp_r.dx2) || opp(tp_r.dy1, tp_r.dy2))
        tr = (d1 >= d2) ? TURN_NONE : TURN_RIGHT;
      else
        tr = TURN_LEFT;
    end else begin
      tr = (tp_r.t1 > tp_r.t2) ? TURN_LEFT : TURN_RIGHT;
    end
  end

  tp_t tp_c;
  always_comb begin
    tp_c.dx1 = DIF_BITS'(bx_r) - DIF_BITS'(ax_r);
    tp_c.dy1 = DIF_BITS'(by_r) - DIF_BITS'(ay_r);
    tp_c.dx2 = DIF_BITS'(cx_r) - DIF_BITS'(bx_r);
    tp_c.dy2 = DIF_BITS'(cy_r) - DIF_BITS'(by_r);
    tp_c.t1  = prd_t'(tp_c.dy2) * prd_t'(tp_c.dx1);
    tp_c.t2  = prd_t'(tp_c.dy1) * prd_t'(tp_c.dx2);
  end

  idx_t ii, ik, ikm, isp1, isp2;
  assign ii   = i_r[IDX_BITS-1:0];
  assign ik   = k_r[IDX_BITS-1:0];
  assign ikm  = IDX_BITS'(k_r - CNT_BITS'(1));
  assign isp1 = IDX_BITS'(sp_r - CNT_BITS'(1));
  assign isp2 = IDX_BITS'(sp_r - CNT_BITS'(2));

  logic i_done, out_free;
  assign i_done   = (i_r >= cnt_r);
  assign out_free = !ovld_r || out_ch.ready;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_LOAD:      if (q_valid) st_nxt = B_DUP;
      B_DUP:       if (i_done) st_nxt = cur_r.last ? B_MIN_RD : B_LOAD;
      B_MIN_RD:    st_nxt = B_MIN;
      B_MIN:       if (i_done) st_nxt = B_SORT_RD;
      B_SORT_RD:   st_nxt = i_done ? B_SCAN_INIT : B_CMP_LD;
      B_CMP_LD:    st_nxt = (k_r <= CNT_BITS'(1)) ? B_SORT_RD : B_T1_EX;
      B_T1_EX:     st_nxt = B_T1_CHK;
      B_T1_CHK:    st_nxt = (tr == TURN_LEFT) ? B_SORT_RD : B_T2_EX;
      B_T2_EX:     st_nxt = B_T2_CHK;
      B_T2_CHK:    st_nxt = (tr == TURN_LEFT) ? B_CMP_LD : B_SORT_RD;
      B_SCAN_INIT: st_nxt = B_SCAN_RD;
      B_SCAN_RD: begin
        if (i_done) st_nxt = B_OUT;
        else if (sp_r > CNT_BITS'(1)) st_nxt = B_SCAN_EX;
      end
      B_SCAN_EX:   st_nxt = B_SCAN_CHK;
      B_SCAN_CHK:  st_nxt = B_SCAN_RD;
      B_OUT:       if (out_free && k_r >= sp_r) st_nxt = B_LOAD;
      default:     st_nxt = B_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    q_pop              = (st_r == B_LOAD) && q_valid;
    out_ch.valid       = ovld_r;
    out_ch.hx          = ohx_r;
    out_ch.hy          = ohy_r;
    out_ch.vtx_count   = osz_r;
    out_ch.dropped     = odrop_r;
    out_ch.end_of_hull = oend_r;
  end

  // datapath sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_LOAD; cnt_r <= '0; ovf_r <= 1'b0; ovld_r <= 1'b0;
      i_r <= '0; k_r <= '0; sp_r <= '0; dup_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        B_LOAD: if (q_valid) begin
          cur_r <= q_data; i_r <= '0; dup_r <= 1'b0;
        end
        // compare against every stored point, then store or flag
        B_DUP: begin
          if (!i_done) begin
            if (sx_r[ii] == cur_r.x && sy_r[ii] == cur_r.y)
              dup_r <= 1'b1;
            i_r <= i_r + 1'b1;
          end else if (!dup_r) begin
            if (cnt_r < CNT_BITS'(MAX_POINTS)) begin
              sx_r[cnt_r[IDX_BITS-1:0]]  <= cur_r.x;
              sy_r[cnt_r[IDX_BITS-1:0]]  <= cur_r.y;
              ord_r[cnt_r[IDX_BITS-1:0]] <= cnt_r[IDX_BITS-1:0];
              cnt_r <= cnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        B_MIN_RD: begin best_r <= '0; i_r <= CNT_BITS'(1); end
        // lowest y, then lowest x; swap it to the front
        B_MIN: begin
          if (!i_done) begin
            if (sy_r[ii] < sy_r[best_r] ||
                (sy_r[ii] == sy_r[best_r] && sx_r[ii] < sx_r[best_r]))
              best_r <= ii;
            i_r <= i_r + 1'b1;
          end else begin
            if (best_r != '0) begin
              ord_r[best_r] <= '0;
              ord_r[0]      <= best_r;
            end
            ox_r <= sx_r[best_r]; oy_r <= sy_r[best_r];
            i_r <= CNT_BITS'(2);
          end
        end
        // insertion sort: take ord[i] as the current point
        B_SORT_RD: if (!i_done) begin
          curi_r <= ord_r[ii];
          k_r    <= i_r;
        end
        // first test: turn(org, prev, cur)
        B_CMP_LD: begin
          if (k_r <= CNT_BITS'(1)) begin
            ord_r[ik] <= curi_r; i_r <= i_r + 1'b1;
          end else begin
            prvi_r <= ord_r[ikm];
            ax_r <= ox_r; ay_r <= oy_r;
            bx_r <= sx_r[ord_r[ikm]]; by_r <= sy_r[ord_r[ikm]];
            cx_r <= sx_r[curi_r];     cy_r <= sy_r[curi_r];
          end
        end
        B_T1_EX: tp_r <= tp_c;
        // left turn: prev stays before cur; else try turn(org, cur, prev)
        B_T1_CHK: begin
          if (tr == TURN_LEFT) begin
            ord_r[ik] <= curi_r; i_r <= i_r + 1'b1;
          end else begin
            ax_r <= ox_r; ay_r <= oy_r;
            bx_r <= sx_r[curi_r]; by_r <= sy_r[curi_r];
            cx_r <= sx_r[prvi_r]; cy_r <= sy_r[prvi_r];
          end
        end
        B_T2_EX: tp_r <= tp_c;
        // left turn: prev goes after cur, shift it up
        B_T2_CHK: begin
          if (tr == TURN_LEFT) begin
            ord_r[ik] <= prvi_r; k_r <= k_r - 1'b1;
          end else begin
            ord_r[ik] <= curi_r; i_r <= i_r + 1'b1;
          end
        end
        B_SCAN_INIT: begin
          stk_r[0] <= ord_r[0];
          stk_r[1] <= ord_r[1];
          sp_r <= (cnt_r > CNT_BITS'(1)) ? CNT_BITS'(2) : CNT_BITS'(1);
          i_r  <= CNT_BITS'(2);
        end
        // stack scan: test top two against ord[i]
        B_SCAN_RD: begin
          if (i_done) begin
            k_r <= '0;
          end else if (sp_r <= CNT_BITS'(1)) begin
            stk_r[sp_r[IDX_BITS-1:0]] <= ord_r[ii];
            sp_r <= sp_r + 1'b1; i_r <= i_r + 1'b1;
          end else begin
            ax_r <= sx_r[stk_r[isp2]]; ay_r <= sy_r[stk_r[isp2]];
            bx_r <= sx_r[stk_r[isp1]]; by_r <= sy_r[stk_r[isp1]];
            cx_r <= sx_r[ord_r[ii]];   cy_r <= sy_r[ord_r[ii]];
          end
        end
        B_SCAN_EX: tp_r <= tp_c;
        // pop only on a TURN_RIGHT result: a clockwise turn or a collinear backtrack
        B_SCAN_CHK: begin
          if (tr == TURN_RIGHT) begin
            sp_r <= sp_r - 1'b1;
          end else begin
            stk_r[sp_r[IDX_BITS-1:0]] <= ord_r[ii];
            sp_r <= sp_r + 1'b1; i_r <= i_r + 1'b1;
          end
        end
        // emit stack bottom to top, then clear the set
        B_OUT: if (out_free) begin
          if (k_r < sp_r) begin
            ohx_r   <= sx_r[stk_r[ik]];
            ohy_r   <= sy_r[stk_r[ik]];
            oend_r  <= (k_r + 1'b1 == sp_r);
            osz_r   <= SIZE_BITS'(sp_r);
            odrop_r <= ovf_r;
            ovld_r  <= 1'b1;
            k_r     <= k_r + 1'b1;
          end else begin
            ovld_r <= 1'b0;
            cnt_r <= '0; ovf_r <= 1'b0; sp_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[src/convex_hull_graham_scan.sv]
// Top level of the Graham scan convex hull block.
// Points arrive on the in_ channel one item each; the item with
// in_final_point set closes the set and starts the hull computation.
// A four entry queue takes points while the back end is busy; each point
// is popped, checked against every stored point for a duplicate and then
// stored. After the last point the back end finds the start point (lowest
// y, then lowest x) and sorts by angle with insertion sort: each turn test
// loads three points, registers the cross products and checks them; a
// compare needs one or two tests, up to about n*n/2 compares. The stack scan
// runs a turn test for each decision with two or more points stacked, and
// pushes directly otherwise. Vertices then leave on the out_ channel,
// counterclockwise from the start point, one per cycle while out_ready is
// high; a stall holds the vertex and, once the queue is full, drops in_ready.
// out_vtx_count and dropped are the same on all vertices of one answer;
// end_of_hull marks the last one. Synchronous active low reset clears the
// queue, the point count, the overflow flag and the output valid.
module convex_hull_graham_scan import chgs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t in_px,
  input  coord_t in_py,
  input  logic   in_final_point,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_hx,
  output coord_t out_hy,
  output logic [SIZE_BITS-1:0] out_vtx_count,
  output logic   out_dropped,
  output logic   out_end_of_hull
);
  chgs_in_if  ich();
  chgs_out_if och();
  logic q_valid, q_pop;
  pt_t  q_data;

  assign ich.valid       = in_valid;
  assign ich.px          = in_px;
  assign ich.py          = in_py;
  assign ich.final_point = in_final_point;
  assign in_ready        = ich.ready;
  assign och.ready       = out_ready;
  assign out_valid       = och.valid;
  assign out_hx          = och.hx;
  assign out_hy          = och.hy;
  assign out_vtx_count   = och.vtx_count;
  assign out_dropped     = och.dropped;
  assign out_end_of_hull = och.end_of_hull;

  chgs_front u_front (.clk, .rst_n, .in_ch(ich), .q_valid, .q_data, .q_pop);
  chgs_back  u_back  (.clk, .rst_n, .q_valid, .q_data, .q_pop, .out_ch(och));
endmodule

[src/chgs_checker.sv]
// Port level checks for the hull block, bound to the top level.
module chgs_checker import chgs_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [SIZE_BITS-1:0] out_vtx_count,
  input logic out_end_of_hull
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vtx_count))
    else $error("stalled vertex changed");
  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vtx_count != '0)
    else $error("zero hull size");
  a_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_end_of_hull ##1 out_valid |-> $stable(out_vtx_count))
    else $error("hull size changed within answer");
endmodule

bind convex_hull_graham_scan chgs_checker u_chk (.*);
